FILE: rtl/ita_pkg.sv
// shared types, codes and constants of the id table allocator
`default_nettype none
package ita_pkg;

	// default parameter values
	localparam int DEF_ENTRIES    = 512;
	localparam int DEF_FIRST_ID   = 1;
	localparam int DEF_VALUE_BITS = 64;

	// free bitmap word geometry
	localparam int WORD_BITS = 32;
	localparam int WORD_SH   = 5;
	typedef logic [WORD_SH-1:0]   bit_idx_t;
	typedef logic [WORD_BITS-1:0] map_word_t;

	// beat field widths
	localparam int OP_W       = 2;
	localparam int ID_W       = 9;
	localparam int VAL_W      = 64;
	localparam int STATE_W    = 2;
	localparam int STAT_W     = 2;
	localparam int IN_DATA_W  = 80;
	localparam int IN_USED_W  = ID_W + VAL_W;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_USED_W = ID_W + VAL_W + STATE_W + STAT_W;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_SET   = 2'd2,
		OP_GET   = 2'd3
	} op_t;

	typedef enum logic [STATE_W-1:0] {
		TAG_FREE     = 2'd0,
		TAG_RESERVED = 2'd1,
		TAG_HOLDING  = 2'd2
	} tag_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK           = 2'd0,
		STAT_FULL         = 2'd1,
		STAT_BAD_ID       = 2'd2,
		STAT_NOT_RESERVED = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr;     // clearing pass step
		logic load;    // capture the request beat
		logic rd;      // read tag, value and bitmap word
		logic commit;  // write back and load the result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;  // last entry of the clearing pass
		logic out_free;  // result register can take a beat
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/ita_ctrl.sv
// sequencing controller of the id table allocator
`default_nettype none
module ita_ctrl import ita_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) state_nxt = S_READ;
			end
			S_READ: begin
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_READ: begin
				cmd.rd = 1'b1;
			end
			S_EXEC: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/ita_dp.sv
// datapath of the id table allocator: tag, value and bitmap memories, search, result register
`default_nettype none
module ita_dp import ita_pkg::*; #(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int FIRST_ID   = DEF_FIRST_ID,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic [OP_W-1:0]       s_tuser,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	localparam int EA_W   = $clog2(ENTRIES);
	localparam int NWORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	typedef logic [EA_W-1:0]       ea_t;
	typedef logic [WIDX_W-1:0]     widx_t;
	typedef logic [VALUE_BITS-1:0] val_t;

	// bits of a bitmap word that alloc may hand out
	function automatic map_word_t avail_mask(input widx_t w);
		map_word_t m;
		int        idx;
		m = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			idx  = (int'(w) << WORD_SH) + j;
			m[j] = (idx >= FIRST_ID) && (idx < ENTRIES);
		end
		return m;
	endfunction

	function automatic widx_t first_word(input logic [NWORDS-1:0] v);
		widx_t r;
		r = '0;
		for (int i = NWORDS - 1; i >= 0; i--) begin
			if (v[i]) r = widx_t'(i);
		end
		return r;
	endfunction

	function automatic bit_idx_t first_bit(input map_word_t v);
		bit_idx_t r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) r = bit_idx_t'(i);
		end
		return r;
	endfunction

	// storage
	tag_t      tag_mem [ENTRIES];
	val_t      val_mem [ENTRIES];
	map_word_t map_mem [NWORDS];
	logic [NWORDS-1:0] full_q;  // word has nothing left to allocate

	// request registers
	op_t             op_q;
	logic [ID_W-1:0] id_q;
	val_t            val_q;

	// read results
	tag_t      tag_q;
	val_t      rval_q;
	map_word_t map_q;
	widx_t     word_q;
	logic      none_q;

	ea_t clr_cnt_q;

	// result register
	logic                  out_valid_q;
	logic [ID_W-1:0]       out_alloc_id_q;
	logic [VAL_W-1:0]      out_read_value_q;
	logic [STATE_W-1:0]    out_state_q;
	logic [STAT_W-1:0]     out_status_q;

	ea_t      id_ea;
	widx_t    id_word;
	widx_t    clr_word;
	widx_t    rd_word;
	logic     id_lt;
	logic     id_usable;
	map_word_t avail;
	map_word_t cand;
	bit_idx_t bitpos;
	bit_idx_t map_bit;
	logic     alloc_ok;

	// commit-time decisions
	logic          tag_we;
	tag_t          tag_wd;
	ea_t           tag_wa;
	logic          val_we;
	logic          map_we;
	logic          map_set;
	map_word_t     new_map;
	logic [ID_W-1:0]    res_alloc_id;
	logic [VAL_W-1:0]   res_read_value;
	logic [STATE_W-1:0] res_state;
	stat_t              res_status;

	assign id_ea     = ea_t'(id_q);
	assign id_word   = widx_t'(id_ea >> WORD_SH);
	assign clr_word  = widx_t'(clr_cnt_q >> WORD_SH);
	assign id_lt     = 32'(id_q) < 32'(ENTRIES);
	assign id_usable = (id_q != '0) && id_lt;
	assign rd_word   = (op_q == OP_ALLOC) ? first_word(~full_q) : id_word;

	assign sts.clr_last = (clr_cnt_q == ea_t'(ENTRIES - 1));
	assign sts.out_free = !out_valid_q || m_tready;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(s_tuser);
			id_q  <= s_tdata[ID_W-1:0];
			val_q <= val_t'(s_tdata[ID_W +: VAL_W]);
		end
	end

	// memory read stage
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			tag_q  <= tag_mem[id_ea];
			rval_q <= val_mem[id_ea];
			map_q  <= map_mem[rd_word];
			word_q <= rd_word;
			none_q <= &full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + ea_t'(1);
		end
	end

	assign avail    = avail_mask(word_q);
	assign cand     = avail & ~map_q;
	assign bitpos   = first_bit(cand);
	assign alloc_ok = !none_q && (cand != '0);

	always_comb begin
		tag_we         = 1'b0;
		tag_wd         = TAG_FREE;
		tag_wa         = id_ea;
		val_we         = 1'b0;
		map_we         = 1'b0;
		map_set        = 1'b0;
		map_bit        = bit_idx_t'(id_ea);
		res_alloc_id   = '0;
		res_read_value = '0;
		res_state      = '0;
		res_status     = STAT_OK;
		unique case (op_q)
			OP_ALLOC: begin
				if (alloc_ok) begin
					tag_we       = 1'b1;
					tag_wd       = TAG_RESERVED;
					tag_wa       = ea_t'({word_q, bitpos});
					map_we       = 1'b1;
					map_set      = 1'b1;
					map_bit      = bitpos;
					res_alloc_id = ID_W'({word_q, bitpos});
				end else begin
					res_status = STAT_FULL;
				end
			end
			OP_FREE: begin
				if (id_usable) begin
					tag_we = 1'b1;
					map_we = 1'b1;
				end else begin
					res_status = STAT_BAD_ID;
				end
			end
			OP_SET: begin
				if (!id_usable) begin
					res_status = STAT_BAD_ID;
				end else if (tag_q != TAG_RESERVED) begin
					res_status = STAT_NOT_RESERVED;
				end else if (val_q == '0) begin
					tag_we = 1'b1;
					map_we = 1'b1;
				end else begin
					tag_we  = 1'b1;
					tag_wd  = TAG_HOLDING;
					val_we  = 1'b1;
					map_we  = 1'b1;
					map_set = 1'b1;
				end
			end
			OP_GET: begin
				if (!id_lt) begin
					res_status = STAT_BAD_ID;
				end else begin
					res_state = STATE_W'(tag_q);
					if (tag_q == TAG_HOLDING) res_read_value = VAL_W'(rval_q);
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	always_comb begin
		new_map          = map_q;
		new_map[map_bit] = map_set;
	end

	// tag memory: clearing pass or commit
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			tag_mem[clr_cnt_q] <= TAG_FREE;
		end else if (cmd.commit && tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && val_we) begin
			val_mem[id_ea] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			map_mem[clr_word] <= '0;
		end else if (cmd.commit && map_we) begin
			map_mem[word_q] <= new_map;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '1;
		end else if (cmd.clr) begin
			full_q[clr_word] <= ~|avail_mask(clr_word);
		end else if (cmd.commit && map_we) begin
			full_q[word_q] <= ~|(avail & ~new_map);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_alloc_id_q   <= res_alloc_id;
			out_read_value_q <= res_read_value;
			out_state_q      <= res_state;
			out_status_q     <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_status_q, out_state_q,
		out_read_value_q, out_alloc_id_q};

endmodule
`default_nettype wire

FILE: rtl/id_table_allocator_top.sv
// top level of the id table allocator
`default_nettype none
// Table of ENTRIES IDs, each free, reserved or holding a value, served one request
// beat at a time: alloc reserves the lowest free ID at or above FIRST_ID, free clears an
// entry, set stores a value into a reserved entry (zero frees it), get reads value and
// state. Every request beat gives exactly one result beat. After a request is accepted,
// a read step reads the tag, value and free bitmap memories (the bitmap word is picked
// by a priority search over a per-word "full" summary), and a write-back commit step
// then loads the result register. A new request is taken in the cycle after the commit,
// so the block takes no new request while one is in flight; a stalled result holds the
// commit until its register frees. After reset a clearing pass marks every tag free
// before the first request is taken; values need no clearing since they are read only
// from entries that hold one.
module id_table_allocator_top import ita_pkg::*; #(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int FIRST_ID   = DEF_FIRST_ID,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request beat
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [OP_W-1:0]       s_tuser,  // op
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // id[8:0], value[72:9], zero pad
	// result beat
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata   // alloc_id[8:0], read_value[72:9],
	                                             // entry_state[74:73], status[76:75], zero pad
);

	cmd_t cmd;  // sequencing commands
	sts_t sts;  // datapath status back to the controller

	// controller: clearing pass, then capture / read / commit per request
	ita_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: memories, free search and result register
	ita_dp #(
		.ENTRIES    (ENTRIES),
		.FIRST_ID   (FIRST_ID),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

FILE: dv/ita_checker.sv
// result checker of the id table allocator: mirrors the table and compares result beats
`timescale 1ns / 1ps
module ita_checker import ita_pkg::*; #(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int FIRST_ID   = DEF_FIRST_ID,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [OP_W-1:0]       s_tuser,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	output int                         fails,
	output int                         pending,
	output int                         full_hits
);

	localparam int RV_LO = ID_W;
	localparam int ES_LO = ID_W + VAL_W;
	localparam int SS_LO = ES_LO + STATE_W;
	localparam logic [VAL_W-1:0] VALUE_MASK = {VAL_W{1'b1}} >> (VAL_W - VALUE_BITS);

	typedef struct packed {
		logic [ID_W-1:0]  alloc_id;
		logic [VAL_W-1:0] read_value;
		tag_t             entry_state;
		stat_t            status;
	} outcome_t;

	tag_t             id_tags [ENTRIES];
	logic [VAL_W-1:0] id_values [ENTRIES];
	outcome_t         due_results [$];
	outcome_t         want;
	outcome_t         got;
	int               fail_n;
	int               full_n;

	// serve one request on the mirrored table and give the result it must produce
	function automatic outcome_t serve_request(op_t op, logic [ID_W-1:0] id,
			logic [VAL_W-1:0] val);
		outcome_t         r;
		logic [VAL_W-1:0] kept;
		bit               found;
		r.alloc_id    = '0;
		r.read_value  = '0;
		r.entry_state = TAG_FREE;
		r.status      = STAT_OK;
		kept          = val & VALUE_MASK;
		found         = 1'b0;
		case (op)
			OP_ALLOC: begin
				for (int i = FIRST_ID; i < ENTRIES; i++) begin
					if (!found && id_tags[i] == TAG_FREE) begin
						id_tags[i] = TAG_RESERVED;
						r.alloc_id = ID_W'(i);
						found      = 1'b1;
					end
				end
				if (!found)
					r.status = STAT_FULL;
			end
			OP_FREE: begin
				if (id == 0 || id >= ENTRIES)
					r.status = STAT_BAD_ID;
				else
					id_tags[id] = TAG_FREE;
			end
			OP_SET: begin
				if (id == 0 || id >= ENTRIES) begin
					r.status = STAT_BAD_ID;
				end else if (id_tags[id] != TAG_RESERVED) begin
					r.status = STAT_NOT_RESERVED;
				end else if (kept == '0) begin
					id_tags[id] = TAG_FREE;
				end else begin
					id_values[id] = kept;
					id_tags[id]   = TAG_HOLDING;
				end
			end
			default: begin
				if (id >= ENTRIES) begin
					r.status = STAT_BAD_ID;
				end else begin
					r.entry_state = id_tags[id];
					if (id_tags[id] == TAG_HOLDING)
						r.read_value = id_values[id];
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [VAL_W-1:0] want_v, logic [VAL_W-1:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want_v, got_v);
			fail_n++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				id_tags[i] = TAG_FREE;
			due_results.delete();
			fail_n = 0;
			full_n = 0;
			fails     <= 0;
			pending   <= 0;
			full_hits <= 0;
		end else begin
			// result side first: a result never belongs to a request taken at the same edge
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t ns: result beat 0x%0h with nothing expected", $time, m_tdata);
					fail_n++;
				end else begin
					want = due_results.pop_front();
					check_field("alloc_id", want.alloc_id, m_tdata[ID_W-1:0]);
					check_field("read_value", want.read_value, m_tdata[RV_LO +: VAL_W]);
					check_field("entry_state", want.entry_state, m_tdata[ES_LO +: STATE_W]);
					check_field("status", want.status, m_tdata[SS_LO +: STAT_W]);
					check_field("pad", '0, m_tdata[OUT_DATA_W-1:OUT_USED_W]);
				end
			end
			if (s_tvalid && s_tready) begin
				got = serve_request(op_t'(s_tuser), s_tdata[ID_W-1:0], s_tdata[ID_W +: VAL_W]);
				if (got.status == STAT_FULL)
					full_n++;
				due_results.push_back(got);
			end
			fails     <= fail_n;
			pending   <= due_results.size();
			full_hits <= full_n;
		end
	end

endmodule

FILE: dv/tb.sv
// testbench top of the id table allocator: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb import ita_pkg::*;;

	localparam int N_ENTRIES  = DEF_ENTRIES;
	localparam int N_FIRST_ID = DEF_FIRST_ID;
	localparam int N_VAL_BITS = DEF_VALUE_BITS;
	// enough random requests to bring the total near 1850 beats
	localparam int N_RANDOM   = 1320;
	// settle time after the last result
	localparam int SETTLE_CYC = 20;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [OP_W-1:0]       s_tuser  = '0;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	int fails;
	int pending;
	int full_hits;

	// requests sent per op, for the summary
	int n_op [4];
	// beats left in the current sender burst
	int burst_left;

	// receiver stall generator state
	logic [15:0] rx_cyc;
	int          rx_hold;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	id_table_allocator_top #(
		.ENTRIES    (N_ENTRIES),
		.FIRST_ID   (N_FIRST_ID),
		.VALUE_BITS (N_VAL_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// watches both channels, mirrors the table and compares every result beat
	ita_checker #(
		.ENTRIES    (N_ENTRIES),
		.FIRST_ID   (N_FIRST_ID),
		.VALUE_BITS (N_VAL_BITS)
	) u_table_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fails     (fails),
		.pending   (pending),
		.full_hits (full_hits)
	);

	// receiver stalls: the pattern steps in turn through always ready,
	// mostly ready, long stall / short ready runs, and mostly stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cyc   <= '0;
			rx_hold  <= 0;
		end else begin
			rx_cyc <= rx_cyc + 16'd1;
			case (rx_cyc[9:8])
				2'd0: begin
					m_tready <= 1'b1;
				end
				2'd1: begin
					m_tready <= ($urandom_range(0, 3) != 0);
				end
				2'd2: begin
					if (rx_hold != 0) begin
						rx_hold <= rx_hold - 1;
					end else begin
						// a high ready drops and a low one rises, each held for a random run; low runs are drawn longer
						m_tready <= !m_tready;
						rx_hold  <= m_tready ? $urandom_range(1, 15) : $urandom_range(1, 6);
					end
				end
				default: begin
					m_tready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// present one request beat and hold it until the block takes it
	task automatic offer_request(op_t op, logic [ID_W-1:0] id, logic [VAL_W-1:0] val);
		s_tuser  <= op;
		s_tdata  <= {{(IN_DATA_W - IN_USED_W){1'b0}}, val, id};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_op[int'(op)]++;
	endtask

	// burst pacing: after a burst of random length, usually a gap of random length,
	// so that gaps land on every phase of a request's handling
	task automatic sender_pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_paced(op_t op, logic [ID_W-1:0] id, logic [VAL_W-1:0] val);
		offer_request(op, id, val);
		sender_pace();
	endtask

	// stop sending and wait for every outstanding result
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// one random request: ids lean toward the low end where allocs land,
	// values mix zero, all ones, single bits and full random patterns
	task automatic send_random();
		int               pick;
		op_t              op;
		logic [ID_W-1:0]  id;
		logic [VAL_W-1:0] val;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			op = OP_ALLOC;
		else if (pick < 45)
			op = OP_FREE;
		else if (pick < 80)
			op = OP_SET;
		else
			op = OP_GET;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			id = '0;
		else if (pick < 8)
			id = ID_W'(N_ENTRIES - 1);
		else if (pick < 40)
			id = ID_W'($urandom_range(1, 32));
		else
			id = ID_W'($urandom_range(1, N_ENTRIES - 1));
		pick = $urandom_range(0, 99);
		if (pick < 8)
			val = '0;
		else if (pick < 14)
			val = '1;
		else if (pick < 18)
			val = {{(VAL_W - 1){1'b0}}, 1'b1} << $urandom_range(0, VAL_W - 1);
		else
			val = {$urandom, $urandom};
		send_paced(op, id, val);
	endtask

	initial begin
		burst_left = 0;
		foreach (n_op[i])
			n_op[i] = 0;

		// single reset at the start of the run
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed part: field extremes, every op and the corner cases of the table
		send_paced(OP_GET,   '0,            '0);                      // entry 0 reads free
		send_paced(OP_GET,   ID_W'(511),    '1);                      // top id reads free
		send_paced(OP_ALLOC, ID_W'(511),    '1);                      // first usable id
		send_paced(OP_ALLOC, '0,            '0);
		send_paced(OP_ALLOC, ID_W'(77),     64'h0123_4567_89ab_cdef);
		send_paced(OP_SET,   ID_W'(1),      '1);                      // all ones stored
		send_paced(OP_SET,   ID_W'(2),      '0);                      // zero value frees
		send_paced(OP_SET,   ID_W'(3),      64'h8000_0000_0000_0001);
		send_paced(OP_GET,   ID_W'(1),      '0);
		send_paced(OP_GET,   ID_W'(2),      '0);
		send_paced(OP_GET,   ID_W'(3),      '0);
		send_paced(OP_SET,   ID_W'(1),      64'd5);                   // set on a holding entry
		send_paced(OP_SET,   ID_W'(400),    64'd9);                   // set on a free entry
		send_paced(OP_FREE,  '0,            '1);                      // bad id on free
		send_paced(OP_SET,   '0,            64'd1);                   // bad id beats not reserved
		send_paced(OP_FREE,  ID_W'(3),      '0);
		send_paced(OP_FREE,  ID_W'(3),      '0);                      // already free stays free
		send_paced(OP_ALLOC, '0,            '0);                      // lowest hole is 2
		send_paced(OP_GET,   ID_W'(2),      '0);                      // reads reserved
		send_paced(OP_SET,   ID_W'(2),      64'h5555_5555_aaaa_aaaa);
		send_paced(OP_GET,   ID_W'(2),      '0);
		send_paced(OP_FREE,  ID_W'(511),    '0);
		send_paced(OP_ALLOC, ID_W'(256),    64'hffff_0000_ffff_0000);

		// hold off until the block has answered everything
		wait_results_done();

		// fill the table to the top, the last few allocs see it full
		for (int i = 0; i < N_ENTRIES - 1; i++)
			send_paced(OP_ALLOC, ID_W'($urandom_range(0, N_ENTRIES - 1)), {$urandom, $urandom});

		// random mix on a mostly reserved table: sets turn entries into holders,
		// frees punch holes that allocs then refill from the bottom
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2)
				wait_results_done();
			send_random();
		end

		wait_results_done();
		repeat (SETTLE_CYC) @(posedge clk);

		$display("run covered %0d alloc, %0d free, %0d set and %0d get requests",
			n_op[int'(OP_ALLOC)], n_op[int'(OP_FREE)], n_op[int'(OP_SET)], n_op[int'(OP_GET)]);
		$display("%0d allocs found the table full", full_hits);
		if (fails == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// run limit, several times the slowest correct run
	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/ita_pkg.sv
rtl/ita_ctrl.sv
rtl/ita_dp.sv
rtl/id_table_allocator_top.sv
dv/ita_checker.sv
dv/tb.sv
